[sv/ird_pkg.sv]
package ird_pkg;

    localparam int CODE_BITS = 16;
    localparam int CNT_W     = $clog2(CODE_BITS + 1);
    localparam int TMR_W     = 24;
    localparam int WIN_W     = 16;
    localparam int CFG_W     = 24;
    localparam int IDX_W     = 3;
    localparam int RAW_W     = 16;
    localparam int CHAR_W    = 7;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int KEYS      = 9;

    localparam logic [IDX_W-1:0] REG_SHORT_LOW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_SHORT_HIGH    = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG_LOW      = 3'd2;
    localparam logic [IDX_W-1:0] REG_LONG_HIGH     = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIT_THRESHOLD = 3'd4;
    localparam logic [IDX_W-1:0] REG_TIMER_PERIOD  = 3'd5;

    localparam logic [WIN_W-1:0] RST_SHORT_LOW     = 16'd500;
    localparam logic [WIN_W-1:0] RST_SHORT_HIGH    = 16'd1000;
    localparam logic [WIN_W-1:0] RST_LONG_LOW      = 16'd1500;
    localparam logic [WIN_W-1:0] RST_LONG_HIGH     = 16'd2000;
    localparam logic [WIN_W-1:0] RST_BIT_THRESHOLD = 16'd1500;
    localparam logic [TMR_W-1:0] RST_TIMER_PERIOD  = 24'd40000;

    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;

    localparam logic [31:0] KEY_CODES [KEYS] = '{
        32'h4202, 32'h4102, 32'h4302, 32'h4082, 32'h4282,
        32'h4382, 32'h4042, 32'h4242, 32'h43A2
    };

    localparam logic [CHAR_W-1:0] KEY_CHARS [KEYS] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h37, 7'h38, 7'h39, 7'h2D
    };

    typedef logic [CODE_BITS-1:0] code_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [CHAR_W-1:0] lookup_key(input code_t code);
        logic [CHAR_W-1:0] ch;
        logic [31:0]       c32;
        ch  = CHAR_UNKNOWN;
        c32 = 32'(code);
        for (int i = KEYS - 1; i >= 0; i--)
        begin
            if (c32 == KEY_CODES[i])
            begin
                ch = KEY_CHARS[i];
            end
        end
        return ch;
    endfunction

endpackage

[sv/ird_front.sv]
module ird_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic                        ir_level,
    input  logic                        wr_en,
    input  logic [ird_pkg::IDX_W-1:0]   wr_index,
    input  logic [ird_pkg::CFG_W-1:0]   wr_data,
    output logic                        emit,
    output ird_pkg::code_t              emit_code
);

    logic [ird_pkg::WIN_W-1:0] short_low_reg;
    logic [ird_pkg::WIN_W-1:0] short_high_reg;
    logic [ird_pkg::WIN_W-1:0] long_low_reg;
    logic [ird_pkg::WIN_W-1:0] long_high_reg;
    logic [ird_pkg::WIN_W-1:0] bit_threshold_reg;
    logic [ird_pkg::TMR_W-1:0] timer_period_reg;

    logic                      prev_reg;
    logic [ird_pkg::TMR_W-1:0] cnt_reg, cnt_next;
    logic                      flag_reg, flag_next;
    logic [ird_pkg::CNT_W-1:0] pc_reg, pc_next;
    ird_pkg::code_t            code_reg, code_next;

    logic                      accept;
    logic                      level_edge;
    logic [ird_pkg::TMR_W:0]   cnt_inc;
    logic [ird_pkg::TMR_W-1:0] period;
    logic                      in_window;
    logic [ird_pkg::CNT_W-1:0] pos;
    logic                      fire;
    ird_pkg::code_t            code_mid;

    assign accept = push && !full;

    always_comb
    begin
        level_edge = ir_level != prev_reg;
        cnt_inc    = {1'b0, cnt_reg} + (ird_pkg::TMR_W + 1)'(1);
        period     = (timer_period_reg == '0) ? ird_pkg::TMR_W'(1) : timer_period_reg;
        in_window  = (cnt_reg > ird_pkg::TMR_W'(short_low_reg)
                      && cnt_reg < ird_pkg::TMR_W'(short_high_reg))
                  || (cnt_reg > ird_pkg::TMR_W'(long_low_reg)
                      && cnt_reg < ird_pkg::TMR_W'(long_high_reg));
        pos        = ird_pkg::CNT_W'(ird_pkg::CODE_BITS - 1) - pc_reg;

        cnt_next  = cnt_reg;
        flag_next = flag_reg;
        pc_next   = pc_reg;
        code_next = code_reg;

        if (level_edge)
        begin
            if (flag_reg)
            begin
                pc_next = '0;
            end
            else if (in_window && pc_reg < ird_pkg::CNT_W'(ird_pkg::CODE_BITS))
            begin
                if (cnt_reg >= ird_pkg::TMR_W'(bit_threshold_reg))
                begin
                    code_next = code_reg | (ird_pkg::CODE_BITS'(1) << pos);
                end
                pc_next = pc_reg + ird_pkg::CNT_W'(1);
            end
            cnt_next  = '0;
            flag_next = 1'b0;
        end
        else if (cnt_inc[ird_pkg::TMR_W-1:0] >= period)
        begin
            cnt_next  = '0;
            flag_next = 1'b1;
        end
        else
        begin
            cnt_next = cnt_inc[ird_pkg::TMR_W-1:0];
        end

        code_mid = code_next;
        fire     = flag_next && (pc_next != '0);
        if (fire)
        begin
            code_next = '0;
            pc_next   = '0;
            flag_next = 1'b0;
        end
    end

    assign emit      = accept && fire;
    assign emit_code = code_mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
            pc_reg   <= '0;
            code_reg <= '0;
        end
        else if (accept)
        begin
            prev_reg <= ir_level;
            cnt_reg  <= cnt_next;
            flag_reg <= flag_next;
            pc_reg   <= pc_next;
            code_reg <= code_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_low_reg     <= ird_pkg::RST_SHORT_LOW;
            short_high_reg    <= ird_pkg::RST_SHORT_HIGH;
            long_low_reg      <= ird_pkg::RST_LONG_LOW;
            long_high_reg     <= ird_pkg::RST_LONG_HIGH;
            bit_threshold_reg <= ird_pkg::RST_BIT_THRESHOLD;
            timer_period_reg  <= ird_pkg::RST_TIMER_PERIOD;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ird_pkg::REG_SHORT_LOW:     short_low_reg     <= wr_data[ird_pkg::WIN_W-1:0];
                ird_pkg::REG_SHORT_HIGH:    short_high_reg    <= wr_data[ird_pkg::WIN_W-1:0];
                ird_pkg::REG_LONG_LOW:      long_low_reg      <= wr_data[ird_pkg::WIN_W-1:0];
                ird_pkg::REG_LONG_HIGH:     long_high_reg     <= wr_data[ird_pkg::WIN_W-1:0];
                ird_pkg::REG_BIT_THRESHOLD: bit_threshold_reg <= wr_data[ird_pkg::WIN_W-1:0];
                ird_pkg::REG_TIMER_PERIOD:  timer_period_reg  <= wr_data[ird_pkg::TMR_W-1:0];
                default:                    ;
            endcase
        end
    end

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= ird_pkg::CNT_W'(ird_pkg::CODE_BITS))
        else $error("pulse count above code length");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (pc_reg == '0 && code_reg == '0 && !flag_reg))
        else $error("frame state not cleared after emit");

endmodule

[sv/ird_queue.sv]
module ird_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  ird_pkg::code_t  wr_code,
    input  logic            rd,
    output ird_pkg::code_t  rd_code,
    output ird_pkg::qstat_t stat
);

    ird_pkg::code_t             mem [ird_pkg::QDEPTH];
    ird_pkg::code_t             rd_code_reg;
    logic [ird_pkg::QPTR_W-1:0] wp_reg, rp_reg;
    logic [ird_pkg::QCNT_W-1:0] cnt_reg;
    logic                       do_wr, do_rd;

    assign stat.full  = cnt_reg == ird_pkg::QCNT_W'(ird_pkg::QDEPTH);
    assign stat.empty = cnt_reg == '0;
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_code    = rd_code_reg;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_code;
        end
        if (do_rd)
        begin
            rd_code_reg <= mem[rp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == ird_pkg::QPTR_W'(ird_pkg::QDEPTH - 1))
                          ? '0 : wp_reg + ird_pkg::QPTR_W'(1);
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == ird_pkg::QPTR_W'(ird_pkg::QDEPTH - 1))
                          ? '0 : rp_reg + ird_pkg::QPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + ird_pkg::QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - ird_pkg::QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && stat.full))
        else $error("write into full queue");

endmodule

[sv/ird_back.sv]
module ird_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ird_pkg::qstat_t            qstat,
    input  ird_pkg::code_t             q_code,
    output logic                       q_rd,
    input  logic                       pop,
    output logic                       empty,
    output logic [ird_pkg::CHAR_W-1:0] key_char,
    output logic [ird_pkg::RAW_W-1:0]  raw_code
);

    logic valid_reg;

    assign q_rd     = !qstat.empty && (!valid_reg || pop);
    assign empty    = !valid_reg;
    assign key_char = ird_pkg::lookup_key(q_code);
    assign raw_code = ird_pkg::RAW_W'(q_code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (!valid_reg && !qstat.empty) |=> valid_reg)
        else $error("output stage not refilled from queue");

endmodule

[sv/ir_pulse_distance_key_decoder_top.sv]
// IR pulse-distance key decoder. Push one receiver level sample (ir_level) per
// microsecond tick; a sample is taken every cycle while full is low, and each
// sample is fully handled in the cycle it is taken. When a frame times out
// (no edge for timer_period ticks) with at least one stored bit, the code and
// its key character ('?' for an unknown code) reach the result side once the
// queue has stored the code and the read register has loaded it, later while an
// earlier result still waits. Results pass through a two-entry queue and its
// read register, so full rises only when three undelivered results are
// waiting. Write the six timing registers through wr_en/wr_index/wr_data only
// while no result is pending; unused indexes are ignored.
module ir_pulse_distance_key_decoder_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       ir_level,
    output logic                       empty,
    input  logic                       pop,
    output logic [ird_pkg::CHAR_W-1:0] key_char,
    output logic [ird_pkg::RAW_W-1:0]  raw_code,
    input  logic                       wr_en,
    input  logic [ird_pkg::IDX_W-1:0]  wr_index,
    input  logic [ird_pkg::CFG_W-1:0]  wr_data
);

    ird_pkg::qstat_t qstat;
    logic            emit;
    ird_pkg::code_t  emit_code;
    logic            q_rd;
    ird_pkg::code_t  q_code;

    assign full = qstat.full;

    ird_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (qstat.full),
        .ir_level  (ir_level),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .emit      (emit),
        .emit_code (emit_code)
    );

    ird_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (emit),
        .wr_code (emit_code),
        .rd      (q_rd),
        .rd_code (q_code),
        .stat    (qstat)
    );

    ird_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .q_code   (q_code),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .key_char (key_char),
        .raw_code (raw_code)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

typedef struct packed {
    logic [ird_pkg::CHAR_W-1:0] key;
    logic [ird_pkg::RAW_W-1:0]  raw;
} key_result_t;

class key_decode_model;
    logic [15:0]                   short_lo;
    logic [15:0]                   short_hi;
    logic [15:0]                   long_lo;
    logic [15:0]                   long_hi;
    logic [15:0]                   one_min;
    logic [23:0]                   period;
    logic                          last_level;
    logic [23:0]                   ticks;
    logic                          timed_out;
    logic [ird_pkg::CNT_W-1:0]     bit_count;
    ird_pkg::code_t                code;
    key_result_t                   due_keys[$];
    int                            errors;

    function new();
        short_lo   = 16'd500;
        short_hi   = 16'd1000;
        long_lo    = 16'd1500;
        long_hi    = 16'd2000;
        one_min    = 16'd1500;
        period     = 24'd40000;
        last_level = 1'b0;
        ticks      = '0;
        timed_out  = 1'b0;
        bit_count  = '0;
        code       = '0;
        errors     = 0;
    endfunction

    function void set_reg(logic [ird_pkg::IDX_W-1:0] idx, logic [ird_pkg::CFG_W-1:0] val);
        case (idx)
            ird_pkg::REG_SHORT_LOW:     short_lo = val[15:0];
            ird_pkg::REG_SHORT_HIGH:    short_hi = val[15:0];
            ird_pkg::REG_LONG_LOW:      long_lo  = val[15:0];
            ird_pkg::REG_LONG_HIGH:     long_hi  = val[15:0];
            ird_pkg::REG_BIT_THRESHOLD: one_min  = val[15:0];
            ird_pkg::REG_TIMER_PERIOD:  period   = val;
            default: ;
        endcase
    endfunction

    function logic [ird_pkg::CHAR_W-1:0] key_for(ird_pkg::code_t c);
        logic [7:0] ch;
        case (c)
            16'h4202: ch = "1";
            16'h4102: ch = "2";
            16'h4302: ch = "3";
            16'h4082: ch = "4";
            16'h4282: ch = "5";
            16'h4382: ch = "7";
            16'h4042: ch = "8";
            16'h4242: ch = "9";
            16'h43A2: ch = "-";
            default:  ch = "?";
        endcase
        return ch[ird_pkg::CHAR_W-1:0];
    endfunction

    function void take_sample(logic lvl);
        logic [23:0] nxt;
        logic [23:0] wrap;
        logic        hit;
        key_result_t res;
        if (lvl != last_level)
        begin
            if (timed_out)
            begin
                bit_count = '0;
            end
            else
            begin
                hit = (ticks > 24'(short_lo) && ticks < 24'(short_hi)) ||
                      (ticks > 24'(long_lo) && ticks < 24'(long_hi));
                if (hit && int'(bit_count) < ird_pkg::CODE_BITS)
                begin
                    if (ticks >= 24'(one_min))
                    begin
                        code[ird_pkg::CODE_BITS - 1 - int'(bit_count)] = 1'b1;
                    end
                    bit_count = bit_count + ird_pkg::CNT_W'(1);
                end
            end
            ticks     = '0;
            timed_out = 1'b0;
        end
        else
        begin
            nxt  = ticks + 24'd1;
            wrap = (period == '0) ? 24'd1 : period;
            if (nxt >= wrap)
            begin
                ticks     = '0;
                timed_out = 1'b1;
            end
            else
            begin
                ticks = nxt;
            end
        end
        last_level = lvl;
        if (timed_out && bit_count != '0)
        begin
            res.key = key_for(code);
            res.raw = code[ird_pkg::RAW_W-1:0];
            due_keys.push_back(res);
            code      = '0;
            bit_count = '0;
            timed_out = 1'b0;
        end
    endfunction

    function void compare_key(logic [ird_pkg::CHAR_W-1:0] kc, logic [ird_pkg::RAW_W-1:0] rc);
        key_result_t want;
        if (due_keys.size() == 0)
        begin
            $display("%0t: key_char %h raw_code %h with none pending", $time, kc, rc);
            errors++;
            return;
        end
        want = due_keys.pop_front();
        if (kc !== want.key)
        begin
            $display("%0t: key_char expected %h actual %h", $time, want.key, kc);
            errors++;
        end
        if (rc !== want.raw)
        begin
            $display("%0t: raw_code expected %h actual %h", $time, want.raw, rc);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int QUIET_LIMIT = 500;
    localparam int SETTLE      = 8;
    localparam logic [ird_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ird_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        push     = 1'b0;
    logic                        ir_level = 1'b0;
    logic                        pop      = 1'b0;
    logic                        wr_en    = 1'b0;
    logic [ird_pkg::IDX_W-1:0]   wr_index = '0;
    logic [ird_pkg::CFG_W-1:0]   wr_data  = '0;
    logic                        full;
    logic                        empty;
    logic [ird_pkg::CHAR_W-1:0]  key_char;
    logic [ird_pkg::RAW_W-1:0]   raw_code;

    key_decode_model keys;
    logic            line_level = 1'b0;
    bit              send_calm  = 1'b0;
    bit              take_calm  = 1'b0;
    int              samples    = 0;

    ir_pulse_distance_key_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .ir_level (ir_level),
        .empty    (empty),
        .pop      (pop),
        .key_char (key_char),
        .raw_code (raw_code),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_sample(input logic lvl);
        int gap;
        gap = $urandom_range(0, 7);
        if (send_calm)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        ir_level <= lvl;
        @(posedge clk);
        while (full) @(posedge clk);
        keys.take_sample(lvl);
        samples++;
    endtask

    // toggle the line, then hold it so the next edge sees an interval of d ticks
    task automatic pulse(input int d);
        line_level = !line_level;
        send_sample(line_level);
        repeat (d) send_sample(line_level);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (keys.due_keys.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ird_pkg::IDX_W-1:0] idx,
                             input logic [ird_pkg::CFG_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        keys.set_reg(idx, val);
    endtask

    task automatic set_timing(input int sl, input int sh, input int ll, input int lh,
                              input int thr, input int per);
        write_reg(ird_pkg::REG_SHORT_LOW,     {8'($urandom), 16'(sl)});
        write_reg(ird_pkg::REG_SHORT_HIGH,    {8'($urandom), 16'(sh)});
        write_reg(ird_pkg::REG_LONG_LOW,      {8'($urandom), 16'(ll)});
        write_reg(ird_pkg::REG_LONG_HIGH,     {8'($urandom), 16'(lh)});
        write_reg(ird_pkg::REG_BIT_THRESHOLD, {8'($urandom), 16'(thr)});
        write_reg(ird_pkg::REG_TIMER_PERIOD,  24'(per));
        wr_en <= 1'b0;
    endtask

    task automatic random_timing();
        int sl;
        int sh;
        int ll;
        int lh;
        int thr;
        sl  = $urandom_range(0, 2);
        sh  = sl + $urandom_range(0, 4);
        ll  = sh + $urandom_range(0, 3) - 1;
        if (ll < 0)
        begin
            ll = 0;
        end
        lh  = ll + $urandom_range(0, 5);
        thr = $urandom_range(sh, ll + 1);
        set_timing(sl, sh, ll, lh, thr, lh + $urandom_range(2, 8));
    endtask

    function automatic int pick_interval(input logic one, input bit exact);
        int lo;
        int hi;
        int top;
        int up;
        int v;
        lo  = one ? int'(keys.long_lo) : int'(keys.short_lo);
        hi  = one ? int'(keys.long_hi) : int'(keys.short_hi);
        top = (keys.period < 24'd64) ? int'(keys.period) - 1 : 63;
        if (top < 0)
        begin
            top = 0;
        end
        up = (hi - 1 < top) ? hi - 1 : top;
        case (exact ? 2 : $urandom_range(0, 9))
            0: v = $urandom_range(0, top);
            1:
            begin
                case ($urandom_range(0, 5))
                    0: v = lo;
                    1: v = lo + 1;
                    2: v = hi;
                    3: v = hi - 1;
                    4: v = int'(keys.one_min);
                    default: v = int'(keys.one_min) - 1;
                endcase
            end
            default: v = (up > lo) ? $urandom_range(lo + 1, up) : $urandom_range(0, top);
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > top)
        begin
            v = top;
        end
        return v;
    endfunction

    task automatic send_frame(input logic [15:0] code, input int nbits, input int tail,
                              input bit exact);
        for (int k = 0; k < nbits; k++)
        begin
            pulse(pick_interval((k < 16) ? code[15 - k] : 1'($urandom), exact));
        end
        pulse(tail);
    endtask

    initial
    begin
        int         quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || wr_en)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("ir_pulse_distance_key_decoder_top: mismatch");
        $finish;
    end

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                take_calm = !take_calm;
            end
            gap = $urandom_range(0, 7);
            if (take_calm)
            begin
                gap = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            keys.compare_key(key_char, raw_code);
        end
    end

    initial
    begin
        int             frames;
        int             idx;
        int             nbits;
        int             tail;
        logic [15:0]    code;
        keys = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: a short interval below the reset window, so no bit is stored
        send_calm = 1'b1;
        pulse(3);
        pulse(0);
        drain();

        send_calm = 1'b0;
        set_timing(1, 3, 3, 5, 4, 8);
        pulse(8);
        for (int i = 0; i < ird_pkg::KEYS; i++)
        begin
            send_frame(ird_pkg::KEY_CODES[i][15:0], 16, 8, 1'b1);
        end
        send_frame(16'hFFFF, 16, 8, 1'b1);
        send_frame(16'h0000, 16, 8, 1'b1);
        pulse(2);
        pulse(8);
        pulse(4);
        pulse(20);
        pulse(4);
        pulse(8);
        send_frame(16'hA5A5, 20, 8, 1'b1);
        pulse(1);
        pulse(2);
        pulse(3);
        pulse(4);
        pulse(5);
        pulse(7);
        pulse(8);
        drain();

        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_SPARE_HI, 24'hFFFFFF);
        set_timing(0, 65535, 65535, 0, 0, 8);
        send_frame(16'($urandom), $urandom_range(1, 18), 8, 1'b0);
        drain();
        set_timing(65535, 0, 0, 65535, 65535, 8);
        send_frame(16'($urandom), $urandom_range(1, 18), 8, 1'b0);
        drain();
        set_timing(1, 5, 3, 7, 4, 8);
        send_frame(16'($urandom), $urandom_range(1, 18), 8, 1'b0);
        drain();
        set_timing(1, 3, 3, 5, 4, 0);
        repeat (30) send_sample(1'($urandom));
        drain();
        set_timing(1, 3, 3, 5, 4, 1);
        repeat (30) send_sample(1'($urandom));
        drain();
        set_timing(4, 10, 12, 20, 12, 24'hFFFFFF);
        repeat (4) pulse(pick_interval(1'($urandom), 1'b0));
        drain();

        frames = 0;
        while (samples < 1600)
        begin
            if (frames % 4 == 0)
            begin
                drain();
                random_timing();
            end
            send_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0, 1:
                begin
                    idx   = $urandom_range(0, ird_pkg::KEYS - 1);
                    code  = ird_pkg::KEY_CODES[idx][15:0];
                    nbits = 16;
                end
                2:
                begin
                    code  = 16'($urandom);
                    nbits = 16;
                end
                default:
                begin
                    code  = 16'($urandom);
                    nbits = $urandom_range(1, 20);
                end
            endcase
            tail = int'(keys.period);
            if ($urandom_range(0, 5) == 0)
            begin
                tail = $urandom_range(0, 3 * int'(keys.period));
            end
            send_frame(code, nbits, tail, 1'b0);
            frames++;
        end

        drain();
        if (keys.due_keys.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, keys.due_keys.size());
        end
        if (keys.errors == 0 && keys.due_keys.size() == 0)
        begin
            $display("ir_pulse_distance_key_decoder_top: match");
        end
        else
        begin
            $display("ir_pulse_distance_key_decoder_top: mismatch");
        end
        $finish;
    end
endmodule

[sim.f]
sv/ird_pkg.sv
sv/ird_front.sv
sv/ird_queue.sv
sv/ird_back.sv
sv/ir_pulse_distance_key_decoder_top.sv
bench/testbench.sv
